// ===== design/pgmi_pkg.sv =====
// Shared constants and types for the prime-gated modular inverse block.
// No dependencies.
package pgmi_pkg;

    localparam int WIDTH = 32;
    localparam int CW    = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [1:0]       status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_REJECT   = 2'd1;
    localparam status_t ST_NOT_COPR = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_PDIV, S_PEVAL, S_EDIV, S_EUPD, S_EMUL, S_FDIV, S_FIN, S_OUT
    } state_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quot;
        word_t rem;
    } div_rsp_t;

endpackage

// ===== design/pgmi_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on pgmi_pkg.
module pgmi_div
    import pgmi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    word_t         q_reg, q_next;
    logic [WIDTH:0] r_reg, r_next;
    word_t         d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [WIDTH:0] trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[WIDTH-1:0], q_reg[WIDTH-1]};
        if (req.start) begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[WIDTH-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg[WIDTH-1:0];

endmodule

// ===== design/prime_gated_modular_inverse_top.sv =====
// Prime-gated modular inverse: trial-division primality gate, then extended Euclid.
// Every division goes through one shared restoring divider; the number of divisions is
// data dependent, roughly (sqrt(value)/3 + Euclid steps + 1), and the block takes one
// word at a time.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
// Depends on pgmi_pkg and pgmi_div.
module prime_gated_modular_inverse_top
    import pgmi_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [31:0]   s_value,
    input  logic [31:0]   s_modulus,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_inverse,
    output logic [1:0]    m_status
);

    state_t   state_reg, state_next;
    word_t    a_reg, a_next, n_reg, n_next;
    word_t    k_reg, k_next;
    logic     pair_reg, pair_next;
    word_t    ro_reg, ro_next, rc_reg, rc_next;
    word_t    so_reg, so_next, sc_reg, sc_next;
    word_t    q_reg, q_next;
    logic     neg_reg, neg_next;
    word_t    inv_reg, inv_next;
    status_t  st_reg, st_next;
    div_req_t req;
    div_rsp_t rsp;
    word_t    prod_reg, prod_next;

    pgmi_div u_div (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg    <= a_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        pair_reg <= pair_next;
        ro_reg   <= ro_next;
        rc_reg   <= rc_next;
        so_reg   <= so_next;
        sc_reg   <= sc_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        inv_reg  <= inv_next;
        st_reg   <= st_next;
        prod_reg <= prod_next;
    end

    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        pair_next    = pair_reg;
        ro_next      = ro_reg;
        rc_next      = rc_reg;
        so_next      = so_reg;
        sc_next      = sc_reg;
        q_next       = q_reg;
        neg_next     = neg_reg;
        inv_next     = inv_reg;
        st_next      = st_reg;
        prod_next    = prod_reg;
        req.start    = 1'b0;
        req.dividend = a_reg;
        req.divisor  = k_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    a_next     = WIDTH'(s_value);
                    n_next     = WIDTH'(s_modulus);
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                k_next    = WIDTH'(2);
                pair_next = 1'b0;
                if (a_reg < WIDTH'(3) || a_reg >= n_reg) begin
                    inv_next   = '0;
                    st_next    = ST_REJECT;
                    state_next = S_OUT;
                end else if (a_reg < WIDTH'(4)) begin
                    state_next = S_FIN;
                end else begin
                    req.start  = 1'b1;
                    req.divisor = WIDTH'(2);
                    state_next = S_PDIV;
                end
            end
            S_PDIV: begin
                if (rsp.done) begin
                    state_next = S_PEVAL;
                end
            end
            S_PEVAL: begin
                // Quotient is a/k; a divisor past the square root ends the search.
                if (rsp.rem == '0) begin
                    inv_next   = '0;
                    st_next    = ST_REJECT;
                    state_next = S_OUT;
                end else begin
                    if (k_reg == WIDTH'(2)) begin
                        k_next = WIDTH'(3);
                    end else if (k_reg == WIDTH'(3)) begin
                        k_next    = WIDTH'(5);
                        pair_next = 1'b0;
                    end else if (!pair_reg) begin
                        k_next    = k_reg + WIDTH'(2);
                        pair_next = 1'b1;
                    end else begin
                        k_next    = k_reg + WIDTH'(4);
                        pair_next = 1'b0;
                    end
                    if ((k_reg == WIDTH'(3) || pair_reg) &&
                        {1'b0, k_next} > {1'b0, rsp.quot}) begin
                        state_next = S_FIN;
                    end else if (k_reg != WIDTH'(2) && !pair_reg &&
                                 k_reg > rsp.quot) begin
                        state_next = S_FIN;
                    end else begin
                        req.start   = 1'b1;
                        req.divisor = k_next;
                        state_next  = S_PDIV;
                    end
                end
            end
            S_FIN: begin
                ro_next  = a_reg;
                rc_next  = n_reg;
                so_next  = WIDTH'(1);
                sc_next  = '0;
                neg_next = 1'b0;
                req.start    = 1'b1;
                req.dividend = a_reg;
                req.divisor  = n_reg;
                state_next   = S_EDIV;
            end
            S_EDIV: begin
                if (rsp.done) begin
                    q_next     = rsp.quot;
                    state_next = S_EMUL;
                end
            end
            S_EMUL: begin
                prod_next  = WIDTH'(q_reg * sc_reg);
                state_next = S_EUPD;
            end
            S_EUPD: begin
                ro_next  = rc_reg;
                rc_next  = rsp.rem;
                so_next  = sc_reg;
                sc_next  = so_reg + prod_reg;
                neg_next = !neg_reg;
                if (rsp.rem == '0) begin
                    if (rc_reg != WIDTH'(1)) begin
                        inv_next   = '0;
                        st_next    = ST_NOT_COPR;
                        state_next = S_OUT;
                    end else begin
                        req.start    = 1'b1;
                        req.dividend = sc_reg;
                        req.divisor  = n_reg;
                        state_next   = S_FDIV;
                    end
                end else begin
                    req.start    = 1'b1;
                    req.dividend = rc_reg;
                    req.divisor  = rsp.rem;
                    state_next   = S_EDIV;
                end
            end
            S_FDIV: begin
                if (rsp.done) begin
                    st_next = ST_OK;
                    if (neg_reg && rsp.rem != '0) begin
                        inv_next = n_reg - rsp.rem;
                    end else begin
                        inv_next = rsp.rem;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_inverse = 32'(inv_reg);
    assign m_status  = st_reg;

endmodule
